// ===== design/bsc_pkg.sv =====
package bsc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic       MODE_ENC = 1'b0;
  localparam logic       MODE_DEC = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // results caused by one input word: up to four bytes, last/error shared
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
    logic            err;
  } grp_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26)      r = 8'h41 + {2'b00, v};
    else if (v < 6'd52) r = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) r = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) r = 8'h2B;
    else                r = 8'h2F;
    return r;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] dec_sextet(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A)      r = {1'b1, 6'(ch - 8'h41)};
    else if (ch >= 8'h61 && ch <= 8'h7A) r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    else if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    else if (ch == 8'h2B)                r = {1'b1, 6'd62};
    else if (ch == 8'h2F)                r = {1'b1, 6'd63};
    return r;
  endfunction

endpackage

// ===== design/bsc_core.sv =====
module bsc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsc_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              grp_ready,
  output logic              grp_load,
  output bsc_pkg::grp_t     grp
);
  import bsc_pkg::*;

  logic       in_vld_r;
  in_item_t   item_r;
  logic       mode_r;
  logic [1:0] phase_r, phase_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0] pad_r, pad_nxt;
  logic       err_r, err_nxt;

  assign grp_load = in_vld_r && grp_ready;
  assign in_stall = in_vld_r && !grp_ready;

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic [6:0]  dv;
    logic [5:0]  sext;
    logic [23:0] full, shifted;
    logic [2:0]  have, missing, psum;
    b         = item_r.in_byte;
    lst       = item_r.in_last;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    grp       = '0;
    grp.last  = lst;
    dv        = dec_sextet(b);
    sext      = 6'd0;
    full      = '0;
    shifted   = '0;
    have      = {1'b0, phase_r} + 3'd1;
    missing   = 3'd0;
    psum      = 3'd0;
    if (mode_r == MODE_ENC) begin
      case (phase_r)
        2'd0: begin
          grp.bytes[0] = enc_char(b[7:2]);
          if (lst) begin
            grp.bytes[1] = enc_char({b[1:0], 4'b0000});
            grp.bytes[2] = PAD_CHAR;
            grp.bytes[3] = PAD_CHAR;
            grp.cnt      = 3'd4;
            phase_nxt    = 2'd0;
            acc_nxt      = '0;
          end else begin
            grp.cnt   = 3'd1;
            acc_nxt   = {16'd0, b[1:0]};
            phase_nxt = 2'd1;
          end
        end
        2'd1: begin
          grp.bytes[0] = enc_char({acc_r[1:0], b[7:4]});
          if (lst) begin
            grp.bytes[1] = enc_char({b[3:0], 2'b00});
            grp.bytes[2] = PAD_CHAR;
            grp.cnt      = 3'd3;
            phase_nxt    = 2'd0;
            acc_nxt      = '0;
          end else begin
            grp.cnt   = 3'd1;
            acc_nxt   = {14'd0, b[3:0]};
            phase_nxt = 2'd2;
          end
        end
        default: begin
          grp.bytes[0] = enc_char({acc_r[3:0], b[7:6]});
          grp.bytes[1] = enc_char(b[5:0]);
          grp.cnt      = 3'd2;
          phase_nxt    = 2'd0;
          acc_nxt      = '0;
        end
      endcase
      pad_nxt = 2'd0;
      err_nxt = 1'b0;
    end else begin
      if (b == PAD_CHAR) begin
        // pad only counts in the third or fourth place
        if (phase_r >= 2'd2) pad_nxt = pad_r + 2'd1;
        else                 err_nxt = 1'b1;
      end else if (!dv[6]) begin
        err_nxt = 1'b1;
      end else begin
        sext = dv[5:0];
        if (pad_r != 2'd0) err_nxt = 1'b1;
      end
      full = {acc_r, sext};
      if (have < 3'd4 && !lst) begin
        acc_nxt   = full[17:0];
        phase_nxt = have[1:0];
      end else begin
        if (have == 3'd1) begin
          grp.cnt = 3'd1;
          grp.err = 1'b1;
        end else begin
          // missing trailing places act as pads
          missing = 3'd4 - have;
          case (missing)
            3'd1:    shifted = {full[17:0], 6'd0};
            3'd2:    shifted = {full[11:0], 12'd0};
            default: shifted = full;
          endcase
          psum = {1'b0, pad_nxt} + missing;
          grp.cnt      = (psum > 3'd2) ? 3'd1 : 3'd3 - psum;
          grp.bytes[0] = shifted[23:16];
          grp.bytes[1] = shifted[15:8];
          grp.bytes[2] = shifted[7:0];
          grp.err      = err_nxt;
        end
        phase_nxt = 2'd0;
        acc_nxt   = '0;
        pad_nxt   = 2'd0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= MODE_ENC;
      phase_r  <= 2'd0;
      acc_r    <= '0;
      pad_r    <= 2'd0;
      err_r    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_vld_r <= 1'b1;
      else if (grp_load)         in_vld_r <= 1'b0;
      if (cfg_we) begin
        mode_r  <= cfg_wdata;
        phase_r <= 2'd0;
        acc_r   <= '0;
        pad_r   <= 2'd0;
        err_r   <= 1'b0;
      end else if (grp_load) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        pad_r   <= pad_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
  end

endmodule

// ===== design/bsc_emit.sv =====
module bsc_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_load,
  input  bsc_pkg::grp_t      grp,
  output logic               grp_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output bsc_pkg::out_item_t out_data
);
  import bsc_pkg::*;

  grp_t       grp_r;
  logic [2:0] cnt_r;
  logic [1:0] idx_r;
  logic       take;

  assign out_valid = (cnt_r != 3'd0);
  assign take      = out_valid && !out_stall;
  // free once the final word of the held group leaves
  assign grp_ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall);

  assign out_data.out_byte  = grp_r.bytes[idx_r];
  assign out_data.out_last  = grp_r.last && (cnt_r == 3'd1);
  assign out_data.out_error = grp_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (grp_load) begin
      cnt_r <= grp.cnt;
      idx_r <= 2'd0;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) grp_r <= grp;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result count out of range");

  a_idx_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, idx_r} + {1'b0, cnt_r}) <= 4'd4)
    else $error("result index runs past group");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && !out_stall)))
    else $error("group loaded over pending results");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |=> (cnt_r == $past(grp.cnt) && idx_r == 2'd0))
    else $error("group count not taken on load");

endmodule

// ===== design/base64_stream_codec.sv =====
// Base64 (standard alphabet, '=' padding) stream codec. cfg_wdata selects
// encode (0) or decode (1); a write also restarts the current group. Encode
// takes one byte per word and returns one character per word, two on the
// third byte of a group, plus the closing character and '=' pads when the
// word marked last ends a short group. Decode takes one character per word
// and returns up to three bytes when a group of four ends or the message
// ends; invalid characters and misplaced pads decode as zero, and these and
// characters after a pad flag out_error on every byte of that group. An
// input word is taken into an input register, converted combinationally
// and its results loaded into an output group register. The input side
// takes a word every cycle as long as each word yields at most one result
// and the output does not stall; a word yielding several results holds the
// group register until all have left, as the result port moves at most one
// word per cycle. Encoding so holds up the input after every third byte.
module base64_stream_codec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bsc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import bsc_pkg::*;

  grp_t grp;
  logic grp_load;
  logic grp_ready;

  bsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grp_ready (grp_ready),
    .grp_load  (grp_load),
    .grp       (grp)
  );

  bsc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_load  (grp_load),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
